@@ sv/nwsp_pkg.sv @@
// Package with character codes, token codes and tables for the wind sentence parser.
`default_nettype none
package nwsp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] PREFIX_LEN = 3'd6;

  localparam logic [2:0] TOK_HEAD   = 3'd0;
  localparam logic [2:0] TOK_DIR    = 3'd1;
  localparam logic [2:0] TOK_REF    = 3'd2;
  localparam logic [2:0] TOK_SPEED  = 3'd3;
  localparam logic [2:0] TOK_UNIT   = 3'd4;
  localparam logic [2:0] TOK_STATUS = 3'd5;
  localparam logic [2:0] TOK_DONE   = 3'd6;

  localparam logic [30:0] SAT_MAG = 31'h7FFF_FFFF;

  typedef struct packed {
    logic       feed;
    logic       first;
    logic [7:0] ch;
  } nwsp_num_ctl_t;

  // Expected characters of the sentence head "$IIMWV".
  function automatic logic [7:0] mwv_head(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h49;
      3'd3:    c = 8'h4D;
      3'd4:    c = 8'h57;
      3'd5:    c = 8'h56;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // Powers of ten for the supported fraction lengths.
  function automatic logic [19:0] pow10(input logic [2:0] n);
    logic [19:0] p;
    unique case (n)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

@@ sv/nwsp_num_acc.sv @@
// Decimal token accumulator producing a saturated fixed-point value.
`default_nettype none
module nwsp_num_acc #(
  parameter int FRAC_DIGITS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  nwsp_pkg::nwsp_num_ctl_t ctl,
  output logic [31:0]            value
);
  import nwsp_pkg::*;

  localparam int FC_W = $clog2(FRAC_DIGITS + 1);
  localparam logic [19:0] SCALE = pow10(3'(FRAC_DIGITS));

  logic            neg_r, neg_nxt;
  logic [30:0]     mag_r, mag_nxt;
  logic [FC_W-1:0] fc_r, fc_nxt;
  logic            seen_r, seen_nxt;
  logic            stop_r, stop_nxt;

  logic            neg_b, seen_b, stop_b;
  logic [30:0]     mag_b;
  logic [FC_W-1:0] fc_b;
  logic            is_digit;
  logic [3:0]      dval;
  logic [35:0]     int_sum;
  logic [31:0]     frac_sum;
  logic [19:0]     frac_scale;

  assign is_digit   = (ctl.ch >= CH_ZERO) && (ctl.ch <= CH_NINE);
  assign dval       = 4'(ctl.ch - CH_ZERO);

  // A new token starts from a clean number.
  assign neg_b  = ctl.first ? 1'b0 : neg_r;
  assign mag_b  = ctl.first ? '0 : mag_r;
  assign fc_b   = ctl.first ? '0 : fc_r;
  assign seen_b = ctl.first ? 1'b0 : seen_r;
  assign stop_b = ctl.first ? 1'b0 : stop_r;

  assign frac_scale = pow10(3'(FRAC_DIGITS - 1) - 3'(fc_b));
  assign int_sum    = ({5'd0, mag_b} << 3) + ({5'd0, mag_b} << 1)
                    + 36'(24'(dval) * 24'(SCALE));
  assign frac_sum   = {1'b0, mag_b} + 32'(24'(dval) * 24'(frac_scale));

  always_comb begin
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    fc_nxt   = fc_r;
    seen_nxt = seen_r;
    stop_nxt = stop_r;
    if (ctl.feed) begin
      neg_nxt  = neg_b;
      mag_nxt  = mag_b;
      fc_nxt   = fc_b;
      seen_nxt = seen_b;
      stop_nxt = stop_b;
      priority if (ctl.first && ctl.ch == CH_MINUS) begin
        neg_nxt = 1'b1;
      end else if (ctl.first && ctl.ch == CH_PLUS) begin
        neg_nxt = neg_b;
      end else if (stop_b) begin
        stop_nxt = 1'b1;
      end else if (!seen_b) begin
        priority if (is_digit) begin
          mag_nxt = (int_sum > 36'(SAT_MAG)) ? SAT_MAG : int_sum[30:0];
        end else if (ctl.ch == CH_POINT) begin
          seen_nxt = 1'b1;
        end else begin
          stop_nxt = 1'b1;
        end
      end else if (is_digit && (32'(fc_b) < 32'(FRAC_DIGITS))) begin
        mag_nxt = (frac_sum > 32'(SAT_MAG)) ? SAT_MAG : frac_sum[30:0];
        fc_nxt  = fc_b + FC_W'(1);
      end else begin
        stop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r  <= 1'b0;
      mag_r  <= '0;
      fc_r   <= '0;
      seen_r <= 1'b0;
      stop_r <= 1'b0;
    end else begin
      neg_r  <= neg_nxt;
      mag_r  <= mag_nxt;
      fc_r   <= fc_nxt;
      seen_r <= seen_nxt;
      stop_r <= stop_nxt;
    end
  end

  assign value = neg_r ? (32'd0 - {1'b0, mag_r}) : {1'b0, mag_r};

endmodule
`default_nettype wire

@@ sv/nmea_wind_sentence_parser.sv @@
// Top level of the streaming wind sentence parser.
// The item flagged last passes the input register, then the result register.
// One character item per cycle, no sentence gaps; a last item waits on a full output.
// A waiting result in the output register does not block items without last.
// Reset (synchronous, rst_n low) empties both registers and clears sentence state.
// Every result also clears the sentence state for the next sentence.
`default_nettype none
module nmea_wind_sentence_parser #(
  parameter int MAX_CHARS   = 63,
  parameter int FRAC_DIGITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic signed [31:0] out_direction,
  output logic [7:0]         out_reference,
  output logic signed [31:0] out_speed,
  output logic [7:0]         out_wind_unit,
  output logic [7:0]         out_status
);
  import nwsp_pkg::*;

  localparam int CC_W = $clog2(MAX_CHARS + 1);

  // Input register: one character item waiting to be processed.
  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;

  // Sentence state.
  logic [2:0]      tok_r, tok_nxt;
  logic [2:0]      ppos_r, ppos_nxt;
  logic            pok_r, pok_nxt;
  logic [CC_W-1:0] cc_r, cc_nxt;
  logic            in_tok_r, in_tok_nxt;
  logic            ended_r, ended_nxt;
  logic [31:0]     dir_r, dir_nxt;
  logic [7:0]      ref_r, ref_nxt;
  logic [31:0]     spd_r, spd_nxt;
  logic [7:0]      unit_r, unit_nxt;
  logic [7:0]      stat_r, stat_nxt;

  // Result register.
  logic        out_v_r, out_v_nxt;
  logic        ok_r;
  logic [31:0] odir_r, ospd_r;
  logic [7:0]  oref_r, ounit_r, ostat_r;

  logic          go;
  logic          take;
  logic          sent_ok;
  logic [31:0]   num_value;
  nwsp_num_ctl_t num_ctl;

  // Advance the input register unless a result would land on a full output.
  assign go       = s1_v_r && (!s1_last_r || !out_v_r || out_ready);
  assign in_ready = !s1_v_r || go;

  // A character counts while the text is open and within the length limit.
  assign take = go && !ended_r && (32'(cc_r) < MAX_CHARS) && (s1_ch_r != CH_NUL);

  // Feed the number unit with non-comma characters of the direction and speed tokens.
  assign num_ctl.feed  = take && (tok_r == TOK_DIR || tok_r == TOK_SPEED)
                       && (s1_ch_r != CH_COMMA);
  assign num_ctl.first = !in_tok_r;
  assign num_ctl.ch    = s1_ch_r;

  nwsp_num_acc #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_num (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (num_ctl),
    .value (num_value)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_valid && in_ready) begin
      s1_v_nxt = 1'b1;
    end else if (go) begin
      s1_v_nxt = 1'b0;
    end
  end

  // Sentence state update for one character.
  always_comb begin
    tok_nxt    = tok_r;
    ppos_nxt   = ppos_r;
    pok_nxt    = pok_r;
    cc_nxt     = cc_r;
    in_tok_nxt = in_tok_r;
    ended_nxt  = ended_r;
    dir_nxt    = dir_r;
    ref_nxt    = ref_r;
    spd_nxt    = spd_r;
    unit_nxt   = unit_r;
    stat_nxt   = stat_r;
    if (go && !ended_r && (32'(cc_r) < MAX_CHARS) && (s1_ch_r == CH_NUL)) begin
      ended_nxt = 1'b1;
    end
    if (take) begin
      cc_nxt = cc_r + CC_W'(1);
      priority if (tok_r >= TOK_DONE) begin
        tok_nxt = tok_r;
      end else if (tok_r == TOK_STATUS) begin
        // Status is the first character that is not a star; commas count here.
        if (s1_ch_r != CH_STAR) begin
          stat_nxt = s1_ch_r;
          tok_nxt  = TOK_DONE;
        end
      end else if (s1_ch_r == CH_COMMA) begin
        // Close the open token; repeated commas fall through untouched.
        if (in_tok_r) begin
          in_tok_nxt = 1'b0;
          if (tok_r == TOK_HEAD && ppos_r < PREFIX_LEN) begin
            pok_nxt = 1'b0;
          end
          if (tok_r == TOK_DIR) begin
            dir_nxt = num_value;
          end
          if (tok_r == TOK_SPEED) begin
            spd_nxt = num_value;
          end
          tok_nxt = tok_r + 3'd1;
        end
      end else begin
        in_tok_nxt = 1'b1;
        if (!in_tok_r && tok_r == TOK_REF) begin
          ref_nxt = s1_ch_r;
        end
        if (!in_tok_r && tok_r == TOK_UNIT) begin
          unit_nxt = s1_ch_r;
        end
        if (tok_r == TOK_HEAD && ppos_r < PREFIX_LEN) begin
          if (s1_ch_r != mwv_head(ppos_r)) begin
            pok_nxt = 1'b0;
          end
          ppos_nxt = ppos_r + 3'd1;
        end
      end
    end
  end

  assign sent_ok = pok_nxt && (tok_nxt == TOK_DONE);

  always_comb begin
    out_v_nxt = out_v_r;
    if (go && s1_last_r) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      tok_r    <= TOK_HEAD;
      ppos_r   <= '0;
      pok_r    <= 1'b1;
      cc_r     <= '0;
      in_tok_r <= 1'b0;
      ended_r  <= 1'b0;
      dir_r    <= '0;
      ref_r    <= '0;
      spd_r    <= '0;
      unit_r   <= '0;
      stat_r   <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (go && s1_last_r) begin
        // Close the sentence: start over for the next one.
        tok_r    <= TOK_HEAD;
        ppos_r   <= '0;
        pok_r    <= 1'b1;
        cc_r     <= '0;
        in_tok_r <= 1'b0;
        ended_r  <= 1'b0;
        dir_r    <= '0;
        ref_r    <= '0;
        spd_r    <= '0;
        unit_r   <= '0;
        stat_r   <= '0;
      end else begin
        tok_r    <= tok_nxt;
        ppos_r   <= ppos_nxt;
        pok_r    <= pok_nxt;
        cc_r     <= cc_nxt;
        in_tok_r <= in_tok_nxt;
        ended_r  <= ended_nxt;
        dir_r    <= dir_nxt;
        ref_r    <= ref_nxt;
        spd_r    <= spd_nxt;
        unit_r   <= unit_nxt;
        stat_r   <= stat_nxt;
      end
    end
  end

  // Payload registers: capture the character item and the result, no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
    if (go && s1_last_r) begin
      ok_r    <= sent_ok;
      odir_r  <= sent_ok ? dir_nxt : 32'd0;
      oref_r  <= sent_ok ? ref_nxt : 8'd0;
      ospd_r  <= sent_ok ? spd_nxt : 32'd0;
      ounit_r <= sent_ok ? unit_nxt : 8'd0;
      ostat_r <= sent_ok ? stat_nxt : 8'd0;
    end
  end

  assign out_valid      = out_v_r;
  assign out_ok         = ok_r;
  assign out_direction  = $signed(odir_r);
  assign out_reference  = oref_r;
  assign out_speed      = $signed(ospd_r);
  assign out_wind_unit  = ounit_r;
  assign out_status     = ostat_r;

endmodule
`default_nettype wire

@@ sv/nwsp_checker.sv @@
// Port-level checker for the wind sentence parser, bound to the top level.
`default_nettype none
module nwsp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_ok,
  input logic signed [31:0] out_direction,
  input logic [7:0]         out_reference,
  input logic signed [31:0] out_speed,
  input logic [7:0]         out_wind_unit,
  input logic [7:0]         out_status
);
  import nwsp_pkg::*;

  // Hold a stalled result item valid, with its ok flag, direction, speed and status unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_direction)
      && $stable(out_speed) && $stable(out_status))
    else $error("stalled result item changed");

  // A failed sentence carries all-zero values.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_direction == 0 && out_speed == 0
      && out_reference == 0 && out_wind_unit == 0 && out_status == 0)
    else $error("failed sentence with nonzero values");

  // A good sentence has no star or NUL as status and no comma or NUL as reference or wind unit.
  a_ok_chars: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_status != CH_STAR && out_status != CH_NUL
      && out_reference != CH_COMMA && out_reference != CH_NUL
      && out_wind_unit != CH_COMMA && out_wind_unit != CH_NUL)
    else $error("good sentence with delimiter in captured field");

  // With the output empty, the input is always open.
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Drop any result on reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item valid after reset");

endmodule

bind nmea_wind_sentence_parser nwsp_checker u_nwsp_checker (.*);
`default_nettype wire
